// ===== hw/rtl/segment_box_slab_intersect_assert.svh =====
// Assertion macros for the checker file of the segment box test.
`ifndef SEGMENT_BOX_SLAB_INTERSECT_ASSERT_SVH
`define SEGMENT_BOX_SLAB_INTERSECT_ASSERT_SVH

// Same-cycle implication, reset masked.
`define SBSI_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("sbsi assertion failed");

// Next-cycle implication, reset masked.
`define SBSI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("sbsi assertion failed");

`endif

// ===== hw/rtl/sbsi_pkg.sv =====
// Shared constants and types of the segment box slab test.
package sbsi_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int T_FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic vld;
		logic hit;
	} sbsi_ctl_t;
endpackage

// ===== hw/rtl/sbsi_div.sv =====
// Pipelined restoring divider giving a quantised, saturated slab crossing.
module sbsi_div #(
	parameter int NW = 35,
	parameter int DW = 33,
	parameter int TF = 16,
	parameter bit UP = 1'b1
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [TF+2:0] res
);
	import sbsi_pkg::*;

	localparam int XW = (NW > DW + 1) ? NW : DW + 1;
	localparam logic signed [TF+2:0] R_MAX = (TF+3)'((1 << TF) + 1);
	localparam logic signed [TF+2:0] R_MIN = -(TF+3)'(1);

	logic [NW-1:0] mag;
	logic [XW-1:0] mag_x;
	logic [XW-1:0] rem_x;
	logic          neg;
	logic          sat;
	logic          q0;

	logic [DW-1:0] rem_p [TF+1];
	logic [TF:0]   q_p   [TF+1];
	logic [DW-1:0] den_p [TF+1];
	logic          neg_p [TF+1];
	logic          sat_p [TF+1];

	logic [TF+1:0] q_inc;
	logic          nz;

	always_comb begin
		neg   = num[NW-1];
		mag   = neg ? NW'(-num) : NW'(num);
		mag_x = XW'(mag);
		sat   = mag_x >= XW'({den, 1'b0});
		q0    = mag_x >= XW'(den);
		rem_x = q0 ? (mag_x - XW'(den)) : mag_x;
	end

	always_ff @(posedge clk) begin
		rem_p[0] <= rem_x[DW-1:0];
		q_p[0]   <= (TF+1)'(q0);
		den_p[0] <= den;
		neg_p[0] <= neg;
		sat_p[0] <= sat;
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= TF; k++) begin : g_bit
		logic [DW:0] r2;
		logic        ge;
		always_comb begin
			r2 = {rem_p[k-1], 1'b0};
			ge = r2 >= {1'b0, den_p[k-1]};
		end
		always_ff @(posedge clk) begin
			rem_p[k] <= ge ? DW'(r2 - {1'b0, den_p[k-1]}) : r2[DW-1:0];
			q_p[k]   <= {q_p[k-1][TF-1:0], ge};
			den_p[k] <= den_p[k-1];
			neg_p[k] <= neg_p[k-1];
			sat_p[k] <= sat_p[k-1];
		end
	end

	always_comb begin
		nz    = rem_p[TF] != '0;
		q_inc = (TF+2)'(q_p[TF]) + (TF+2)'(UP && nz);
	end

	always_ff @(posedge clk) begin
		priority if (sat_p[TF])
			res <= neg_p[TF] ? R_MIN : R_MAX;
		else if (neg_p[TF])
			res <= (q_p[TF] == '0 && (UP || !nz)) ? '0 : R_MIN;
		else if ((TF+3)'(q_inc) > R_MAX)
			res <= R_MAX;
		else
			res <= (TF+3)'(q_inc);
	end
endmodule

// ===== hw/rtl/sbsi_point.sv =====
// Hit point, distance to centre and face normal, three register stages.
module sbsi_point #(
	parameter int CW = 32,
	parameter int TF = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbsi_pkg::sbsi_ctl_t       ctl,
	input  logic [TF:0]               te,
	input  logic signed [CW-1:0]      s [3],
	input  logic signed [CW-1:0]      d [3],
	input  logic signed [CW-1:0]      c [3],
	output logic                      done,
	output logic                      hit,
	output logic [TF:0]               t_enter,
	output logic signed [CW-1:0]      point [3],
	output logic signed [1:0]         normal [3]
);
	import sbsi_pkg::*;

	localparam int PW = CW + TF + 2;
	localparam logic signed [CW+1:0] V_MAX = (CW+2)'((64'd1 << (CW-1)) - 64'd1);
	localparam logic signed [CW+1:0] V_MIN = -V_MAX - (CW+2)'(1);

	sbsi_ctl_t           ctl_s1, ctl_s2;
	logic [TF:0]         te_s1, te_s2;
	logic signed [PW-1:0] prod_s1 [3];
	logic signed [CW-1:0] s_s1 [3], c_s1 [3], d_s1 [3];
	logic signed [CW-1:0] p_s2 [3];
	logic [CW:0]          dist_s2 [3];
	logic                 dpos_s2 [3], dneg_s2 [3];

	logic signed [CW+1:0] v [3];
	logic [1:0]           best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done   <= ctl_s2.vld;
		end
	end

	// scale the segment by t_enter
	always_ff @(posedge clk) begin
		te_s1 <= te;
		for (int ax = 0; ax < 3; ax++) begin
			prod_s1[ax] <= PW'(d[ax]) * $signed({{(PW-TF-1){1'b0}}, te});
			s_s1[ax]    <= s[ax];
			c_s1[ax]    <= c[ax];
			d_s1[ax]    <= d[ax];
		end
	end

	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			v[ax] = (CW+2)'(prod_s1[ax] >>> TF) + (CW+2)'(s_s1[ax]);
			if (v[ax] > V_MAX)
				v[ax] = V_MAX;
			else if (v[ax] < V_MIN)
				v[ax] = V_MIN;
		end
	end

	always_ff @(posedge clk) begin
		te_s2 <= te_s1;
		for (int ax = 0; ax < 3; ax++) begin
			p_s2[ax]    <= v[ax][CW-1:0];
			dist_s2[ax] <= (v[ax] >= (CW+2)'(c_s1[ax]))
				? (CW+1)'(v[ax] - (CW+2)'(c_s1[ax]))
				: (CW+1)'((CW+2)'(c_s1[ax]) - v[ax]);
			dpos_s2[ax] <= !d_s1[ax][CW-1] && d_s1[ax] != '0;
			dneg_s2[ax] <= d_s1[ax][CW-1];
		end
	end

	always_comb begin
		priority if (dist_s2[0] >= dist_s2[1] && dist_s2[0] >= dist_s2[2])
			best = 2'd0;
		else if (dist_s2[1] >= dist_s2[2])
			best = 2'd1;
		else
			best = 2'd2;
	end

	// drop everything on a miss
	always_ff @(posedge clk) begin
		hit     <= ctl_s2.hit;
		t_enter <= ctl_s2.hit ? te_s2 : '0;
		for (int ax = 0; ax < 3; ax++) begin
			point[ax]  <= ctl_s2.hit ? p_s2[ax] : '0;
			normal[ax] <= (ctl_s2.hit && best == 2'(ax) && dpos_s2[ax]) ? -2'sd1
				: (ctl_s2.hit && best == 2'(ax) && dneg_s2[ax]) ? 2'sd1 : 2'sd0;
		end
	end
endmodule

// ===== hw/rtl/segment_box_slab_intersect.sv =====
// Top level of the segment versus axis-aligned box slab test.
// Takes one segment/box word per clock whenever start is high; busy is
// always low because the pipeline never stalls. Each word yields exactly one
// result word, shown for one cycle with done high, after it has passed
// one setup stage, the pipelined dividers (T_FRAC_BITS + 2 stages, each
// but the last giving one quotient bit), one interval stage and three
// stages for the hit point and normal. Results leave in input order and
// cannot be held off. On a miss every field but done is zero.
module segment_box_slab_intersect #(
	parameter int COORD_WIDTH = sbsi_pkg::COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = sbsi_pkg::T_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] seg_x,
	input  logic signed [COORD_WIDTH-1:0] seg_y,
	input  logic signed [COORD_WIDTH-1:0] seg_z,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic [COORD_WIDTH-2:0]        size_x,
	input  logic [COORD_WIDTH-2:0]        size_y,
	input  logic [COORD_WIDTH-2:0]        size_z,
	output logic                          done,
	output logic                          hit,
	output logic [T_FRAC_BITS:0]          t_enter,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z,
	output logic signed [1:0]             normal_x,
	output logic signed [1:0]             normal_y,
	output logic signed [1:0]             normal_z
);
	import sbsi_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int TF   = T_FRAC_BITS;
	localparam int NW   = CW + 3;     // plane distance in half-LSB units
	localparam int DW   = CW + 1;     // twice the segment magnitude
	localparam int RW   = TF + 3;     // saturated crossing
	localparam int DLAT = TF + 2;     // divider latency
	localparam logic signed [RW-1:0] T_ONE = RW'(1 << TF);

	// word on the ports, per axis
	logic signed [CW-1:0] in_s [3], in_d [3], in_c [3];
	logic [CW-2:0]        in_z [3];

	// setup arithmetic
	logic signed [NW-1:0] s2 [3], lo [3], hi [3];
	logic signed [NW-1:0] ne [3], fa [3];
	logic [DW-1:0]        den [3];
	logic                 dz [3], outside [3];

	// stage 1
	logic                 valid_s1;
	logic signed [NW-1:0] ne_s1 [3], fa_s1 [3];
	logic [DW-1:0]        den_s1 [3];
	logic signed [CW-1:0] s_s1 [3], d_s1 [3], c_s1 [3];
	logic                 dz_s1 [3], out_s1 [3];

	// sideband delay matching the dividers
	logic                 vld_sd [DLAT];
	logic                 miss_sd [DLAT];
	logic [2:0]           dz_sd [DLAT];
	logic signed [CW-1:0] s_sd [DLAT][3], d_sd [DLAT][3], c_sd [DLAT][3];

	logic signed [RW-1:0] ta [3], tb [3];

	// interval stage
	logic signed [RW-1:0] te, tx;
	sbsi_ctl_t            ctl_s2;
	logic [TF:0]          te_s2;
	logic signed [CW-1:0] s_s2 [3], d_s2 [3], c_s2 [3];

	logic signed [CW-1:0] pt [3];
	logic signed [1:0]    nrm [3];

	assign busy = 1'b0;

	assign in_s[0] = start_x;  assign in_s[1] = start_y;  assign in_s[2] = start_z;
	assign in_d[0] = seg_x;    assign in_d[1] = seg_y;    assign in_d[2] = seg_z;
	assign in_c[0] = center_x; assign in_c[1] = center_y; assign in_c[2] = center_z;
	assign in_z[0] = size_x;   assign in_z[1] = size_y;   assign in_z[2] = size_z;

	// Planes in half-LSB units so that the half size stays exact.
	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			s2[ax]  = NW'(in_s[ax]) <<< 1;
			lo[ax]  = (NW'(in_c[ax]) <<< 1) - $signed(NW'(in_z[ax]));
			hi[ax]  = (NW'(in_c[ax]) <<< 1) + $signed(NW'(in_z[ax]));
			dz[ax]  = in_d[ax] == '0;
			outside[ax] = dz[ax] && (s2[ax] < lo[ax] || s2[ax] > hi[ax]);
			if (in_d[ax][CW-1]) begin
				ne[ax]  = s2[ax] - hi[ax];
				fa[ax]  = s2[ax] - lo[ax];
				den[ax] = DW'(-(DW'(in_d[ax]))) << 1;
			end else begin
				ne[ax]  = lo[ax] - s2[ax];
				fa[ax]  = hi[ax] - s2[ax];
				den[ax] = DW'(in_d[ax]) << 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 3; ax++) begin
			ne_s1[ax]  <= ne[ax];
			fa_s1[ax]  <= fa[ax];
			den_s1[ax] <= den[ax];
			s_s1[ax]   <= in_s[ax];
			d_s1[ax]   <= in_d[ax];
			c_s1[ax]   <= in_c[ax];
			dz_s1[ax]  <= dz[ax];
			out_s1[ax] <= outside[ax];
		end
	end

	// Entry crossings round up, exit crossings round down.
	for (genvar ax = 0; ax < 3; ax++) begin : g_axis
		sbsi_div #(.NW(NW), .DW(DW), .TF(TF), .UP(1'b1)) u_div_enter (
			.clk (clk),
			.num (ne_s1[ax]),
			.den (den_s1[ax]),
			.res (ta[ax])
		);
		sbsi_div #(.NW(NW), .DW(DW), .TF(TF), .UP(1'b0)) u_div_exit (
			.clk (clk),
			.num (fa_s1[ax]),
			.den (den_s1[ax]),
			.res (tb[ax])
		);
	end

	// Carry valid and the coordinates alongside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DLAT; k++)
				vld_sd[k] <= 1'b0;
		end else begin
			vld_sd[0] <= valid_s1;
			for (int k = 1; k < DLAT; k++)
				vld_sd[k] <= vld_sd[k-1];
		end
	end

	always_ff @(posedge clk) begin
		miss_sd[0] <= out_s1[0] || out_s1[1] || out_s1[2];
		dz_sd[0]   <= {dz_s1[2], dz_s1[1], dz_s1[0]};
		s_sd[0]    <= s_s1;
		d_sd[0]    <= d_s1;
		c_sd[0]    <= c_s1;
		for (int k = 1; k < DLAT; k++) begin
			miss_sd[k] <= miss_sd[k-1];
			dz_sd[k]   <= dz_sd[k-1];
			s_sd[k]    <= s_sd[k-1];
			d_sd[k]    <= d_sd[k-1];
			c_sd[k]    <= c_sd[k-1];
		end
	end

	// Narrow [0, 1] by each axis that has a non-zero component.
	always_comb begin
		te = '0;
		tx = T_ONE;
		for (int ax = 0; ax < 3; ax++) begin
			if (!dz_sd[DLAT-1][ax]) begin
				if (ta[ax] > te)
					te = ta[ax];
				if (tb[ax] < tx)
					tx = tb[ax];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s2 <= '0;
		else begin
			ctl_s2.vld <= vld_sd[DLAT-1];
			ctl_s2.hit <= vld_sd[DLAT-1] && !miss_sd[DLAT-1] && te <= tx;
		end
	end

	always_ff @(posedge clk) begin
		te_s2 <= (te <= tx) ? te[TF:0] : '0;
		s_s2  <= s_sd[DLAT-1];
		d_s2  <= d_sd[DLAT-1];
		c_s2  <= c_sd[DLAT-1];
	end

	sbsi_point #(.CW(CW), .TF(TF)) u_point (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s2),
		.te      (te_s2),
		.s       (s_s2),
		.d       (d_s2),
		.c       (c_s2),
		.done    (done),
		.hit     (hit),
		.t_enter (t_enter),
		.point   (pt),
		.normal  (nrm)
	);

	assign point_x  = pt[0];
	assign point_y  = pt[1];
	assign point_z  = pt[2];
	assign normal_x = nrm[0];
	assign normal_y = nrm[1];
	assign normal_z = nrm[2];
endmodule

// ===== hw/rtl/sbsi_check.sv =====
// Port-level checker of the segment box test, bound to the top level.
`include "segment_box_slab_intersect_assert.svh"
module sbsi_check #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          hit,
	input logic [T_FRAC_BITS:0]          t_enter,
	input logic signed [COORD_WIDTH-1:0] point_x,
	input logic signed [COORD_WIDTH-1:0] point_y,
	input logic signed [COORD_WIDTH-1:0] point_z,
	input logic signed [1:0]             normal_x,
	input logic signed [1:0]             normal_y,
	input logic signed [1:0]             normal_z
);
	import sbsi_pkg::*;

	`SBSI_ASSERT_NOW(a_never_busy, clk, arst_n, start, !busy)
	`SBSI_ASSERT_NOW(a_miss_zero, clk, arst_n, done && !hit, t_enter == '0 && point_x == '0 && point_y == '0 && point_z == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)
	`SBSI_ASSERT_NOW(a_t_range, clk, arst_n, done && hit, t_enter <= (T_FRAC_BITS+1)'(1 << T_FRAC_BITS))
	`SBSI_ASSERT_NOW(a_one_face, clk, arst_n, done, $countones({normal_x != 2'sd0, normal_y != 2'sd0, normal_z != 2'sd0}) <= 1)
endmodule

bind segment_box_slab_intersect sbsi_check #(
	.COORD_WIDTH (COORD_WIDTH),
	.T_FRAC_BITS (T_FRAC_BITS)
) u_sbsi_check (.*);

// ===== test/testbench.sv =====
// Self-checking bench for the segment versus box slab intersection block.
`timescale 1ns / 1ps

module testbench;
	import sbsi_pkg::*;

	localparam int CW = 32;
	localparam int TF = 16;
	localparam longint T_ONE = 64'sd1 << TF;
	localparam longint C_MAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint C_MIN = -C_MAX - 1;
	localparam int LATENCY = TF + 7;

	typedef struct {
		logic signed [CW-1:0] s [3];
		logic signed [CW-1:0] d [3];
		logic signed [CW-1:0] c [3];
		logic [CW-2:0]        z [3];
	} query_t;

	typedef struct {
		logic                 hit;
		logic [TF:0]          t;
		logic signed [CW-1:0] p [3];
		logic signed [1:0]    n [3];
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, hit;
	logic signed [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CW-1:0] seg_x = '0, seg_y = '0, seg_z = '0;
	logic signed [CW-1:0] center_x = '0, center_y = '0, center_z = '0;
	logic [CW-2:0] size_x = '0, size_y = '0, size_z = '0;
	logic [TF:0] t_enter;
	logic signed [CW-1:0] point_x, point_y, point_z;
	logic signed [1:0] normal_x, normal_y, normal_z;

	query_t  pending_q [$];
	answer_t hit_expect_q [$];
	int errors = 0;
	int words_out = 0;
	int hits_seen = 0;
	bit stim_done = 0;
	bit calm = 0;

	segment_box_slab_intersect i_dut (.*);

	always #2 clk = ~clk;

	// Crossing num/den (den > 0) quantised to signed Q1.TF, saturated to [-1, T_ONE+1].
	function automatic longint crossing_t(longint num, longint den, bit up);
		bit neg;
		longint mag, q, rem, r;
		neg = num < 0;
		mag = neg ? -num : num;
		if (mag >= 2 * den)
			return neg ? -1 : T_ONE + 1;
		q = (mag >= den) ? 1 : 0;
		rem = mag - q * den;
		for (int i = 0; i < TF; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		if (!neg)
			r = q + ((up && rem != 0) ? 1 : 0);
		else
			r = -(q + ((!up && rem != 0) ? 1 : 0));
		if (r < -1) r = -1;
		if (r > T_ONE + 1) r = T_ONE + 1;
		return r;
	endfunction

	function automatic answer_t slab_test(query_t w);
		answer_t a;
		longint s, d, c, lo, hi, ne, fa, den, ta, tb, v, lo16;
		longint te, tx;
		longint spread [3];
		bit ok;
		int best;
		te = 0;
		tx = T_ONE;
		ok = 1;
		a.hit = 0;
		a.t = '0;
		for (int k = 0; k < 3; k++) begin
			a.p[k] = '0;
			a.n[k] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			s = w.s[k];
			d = w.d[k];
			c = w.c[k];
			lo = 2 * c - longint'(w.z[k]);
			hi = 2 * c + longint'(w.z[k]);
			if (d == 0) begin
				if (2 * s < lo || 2 * s > hi) ok = 0;
			end else begin
				if (d > 0) begin
					ne = lo - 2 * s; fa = hi - 2 * s; den = 2 * d;
				end else begin
					ne = 2 * s - hi; fa = 2 * s - lo; den = -2 * d;
				end
				ta = crossing_t(ne, den, 1);
				tb = crossing_t(fa, den, 0);
				if (ta > te) te = ta;
				if (tb < tx) tx = tb;
			end
		end
		if (te > tx) ok = 0;
		if (!ok)
			return a;
		for (int k = 0; k < 3; k++) begin
			d = w.d[k];
			lo16 = d & (T_ONE - 1);
			v = longint'(w.s[k]) + ((d - lo16) >>> TF) * te + ((lo16 * te) >>> TF);
			if (v > C_MAX) v = C_MAX;
			if (v < C_MIN) v = C_MIN;
			a.p[k] = v[CW-1:0];
			spread[k] = v - longint'(w.c[k]);
			if (spread[k] < 0) spread[k] = -spread[k];
		end
		if (spread[0] >= spread[1] && spread[0] >= spread[2]) best = 0;
		else if (spread[1] >= spread[2]) best = 1;
		else best = 2;
		a.hit = 1;
		a.t = te[TF:0];
		if (w.d[best] > 0) a.n[best] = -2'sd1;
		else if (w.d[best] < 0) a.n[best] = 2'sd1;
		return a;
	endfunction

	function automatic logic [CW-1:0] rnd_word();
		return CW'({$urandom, $urandom} >> (64 - CW));
	endfunction

	// Small coordinates around a box so that most segments cross it.
	function automatic query_t aimed_word();
		query_t w;
		int span;
		span = 1 << $urandom_range(8, 22);
		for (int k = 0; k < 3; k++) begin
			w.c[k] = $signed($urandom_range(0, 2 * span)) - span;
			w.z[k] = (CW-1)'($urandom_range(0, 2 * span));
			w.s[k] = w.c[k] + $signed($urandom_range(0, 8 * span)) - 4 * span;
			w.d[k] = ($urandom_range(0, 7) == 0) ? '0 : w.c[k] - w.s[k]
				+ $signed($urandom_range(0, 2 * span)) - span;
			if ($urandom_range(0, 3) == 0) w.d[k] = 2 * w.d[k];
		end
		return w;
	endfunction

	function automatic query_t noise_word();
		query_t w;
		for (int k = 0; k < 3; k++) begin
			w.s[k] = rnd_word();
			w.d[k] = ($urandom_range(0, 9) == 0) ? '0 : rnd_word();
			w.c[k] = rnd_word();
			w.z[k] = (CW-1)'(rnd_word());
		end
		return w;
	endfunction

	function automatic query_t unit_box(longint sx, longint sy, longint sz,
		longint dx, longint dy, longint dz);
		query_t w;
		w.s = '{CW'(sx), CW'(sy), CW'(sz)};
		w.d = '{CW'(dx), CW'(dy), CW'(dz)};
		w.c = '{'0, '0, '0};
		w.z = '{(CW-1)'(2 * T_ONE), (CW-1)'(2 * T_ONE), (CW-1)'(2 * T_ONE)};
		return w;
	endfunction

	// Feed the block: push words in, idle at random except during the calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			query_t w;
			if (start && !busy) begin
				hit_expect_q.push_back(slab_test(pending_q.pop_front()));
			end
			if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
				w = pending_q[0];
				start <= 1'b1;
				start_x <= w.s[0]; start_y <= w.s[1]; start_z <= w.s[2];
				seg_x <= w.d[0]; seg_y <= w.d[1]; seg_z <= w.d[2];
				center_x <= w.c[0]; center_y <= w.c[1]; center_z <= w.c[2];
				size_x <= w.z[0]; size_y <= w.z[1]; size_z <= w.z[2];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			answer_t e;
			if (hit_expect_q.size() == 0) begin
				$error("result word with nothing outstanding");
				errors++;
			end else begin
				e = hit_expect_q.pop_front();
				words_out++;
				if (hit) hits_seen++;
				if (hit !== e.hit) begin
					$error("hit: expected %0d actual %0d", e.hit, hit); errors++;
				end
				if (t_enter !== e.t) begin
					$error("t_enter: expected %0d actual %0d", e.t, t_enter); errors++;
				end
				if (point_x !== e.p[0]) begin
					$error("point_x: expected %0d actual %0d", e.p[0], point_x); errors++;
				end
				if (point_y !== e.p[1]) begin
					$error("point_y: expected %0d actual %0d", e.p[1], point_y); errors++;
				end
				if (point_z !== e.p[2]) begin
					$error("point_z: expected %0d actual %0d", e.p[2], point_z); errors++;
				end
				if (normal_x !== e.n[0]) begin
					$error("normal_x: expected %0d actual %0d", e.n[0], normal_x); errors++;
				end
				if (normal_y !== e.n[1]) begin
					$error("normal_y: expected %0d actual %0d", e.n[1], normal_y); errors++;
				end
				if (normal_z !== e.n[2]) begin
					$error("normal_z: expected %0d actual %0d", e.n[2], normal_z); errors++;
				end
			end
		end
	end

	initial begin
		query_t w;
		longint h;
		h = T_ONE / 2;
		// Axis hits from each side, corners, grazing faces, start inside.
		pending_q.push_back(unit_box(-2 * T_ONE, 0, 0, 4 * T_ONE, 0, 0));
		pending_q.push_back(unit_box(2 * T_ONE, 0, 0, -4 * T_ONE, 0, 0));
		pending_q.push_back(unit_box(0, -2 * T_ONE, 0, 0, 4 * T_ONE, 0));
		pending_q.push_back(unit_box(0, 0, 2 * T_ONE, 0, 0, -4 * T_ONE));
		pending_q.push_back(unit_box(0, 0, 0, T_ONE, T_ONE, T_ONE));
		pending_q.push_back(unit_box(-2 * T_ONE, -2 * T_ONE, -2 * T_ONE,
			4 * T_ONE, 4 * T_ONE, 4 * T_ONE));
		pending_q.push_back(unit_box(-2 * T_ONE, T_ONE, 0, 4 * T_ONE, 0, 0));
		pending_q.push_back(unit_box(-2 * T_ONE, T_ONE + 1, 0, 4 * T_ONE, 0, 0));
		pending_q.push_back(unit_box(-2 * T_ONE, 0, 0, T_ONE, 0, 0));
		pending_q.push_back(unit_box(-2 * T_ONE, 0, 0, T_ONE - 1, 0, 0));
		pending_q.push_back(unit_box(-3 * h, -h, 0, 3, 2, 0));
		pending_q.push_back(unit_box(0, 0, 0, 0, 0, 0));
		pending_q.push_back(unit_box(5 * T_ONE, 0, 0, 0, 0, 0));
		pending_q.push_back(unit_box(-T_ONE, -T_ONE, -T_ONE, 2 * T_ONE, 2 * T_ONE, T_ONE));
		// Full-range extremes.
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 3; k++) begin
				w.s[k] = i[0] ? CW'(C_MAX) : CW'(C_MIN);
				w.d[k] = i[0] ? CW'(C_MIN) : CW'(C_MAX);
				w.c[k] = i[1] ? CW'(C_MAX) : CW'(C_MIN);
				w.z[k] = i[1] ? '1 : '0;
			end
			pending_q.push_back(w);
		end
		w = unit_box(C_MIN, 0, 0, C_MAX, 0, 0);
		w.z[0] = '1;
		pending_q.push_back(w);
		for (int i = 0; i < 450; i++)
			pending_q.push_back(($urandom_range(0, 99) < 75) ? aimed_word() : noise_word());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// Hold a run of back-to-back words part way through.
		wait (pending_q.size() < 300);
		calm = 1;
		wait (pending_q.size() < 200);
		calm = 0;
		wait (pending_q.size() == 0 && !start);
		stim_done = 1;
		wait (hit_expect_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d result words, %0d of them hits, with random gaps",
			words_out, hits_seen);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#200000;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sbsi_pkg.sv
hw/rtl/sbsi_div.sv
hw/rtl/sbsi_point.sv
hw/rtl/segment_box_slab_intersect.sv
hw/rtl/sbsi_check.sv
test/testbench.sv
